// ===== rtl/fac_pkg.sv =====
`default_nettype none

package fac_pkg;

	// result codes
	typedef enum logic [2:0] {
		V_KNOWN    = 3'd0,
		V_NEW      = 3'd1,
		V_NOMEM    = 3'd2,
		V_SHORT    = 3'd3,
		V_MISMATCH = 3'd4,
		V_FOREIGN  = 3'd5,
		V_FULL     = 3'd6
	} verdict_t;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX  = 2'd1;

	// reset values of the registers
	localparam logic [15:0] MAX_MSG_RST = 16'd8216;
	localparam logic [23:0] PREFIX_RST  = 24'h00163E;

	// smallest length that carries a header
	localparam logic [15:0] HDR_BYTES = 16'd4;

	// search request from the front end to the table
	typedef struct packed {
		logic        start;
		logic [23:0] suffix;
	} search_req_t;

	// search result back to the front end
	typedef struct packed {
		logic       done;
		verdict_t   verdict;
		logic [7:0] index;
	} search_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/fac_check.sv =====
`default_nettype none

// Admission checks on one frame descriptor, in priority order.
module fac_check (
	input  wire logic [15:0]      received_length,
	input  wire logic [31:0]      header_length,
	input  wire logic [47:0]      source_address,
	input  wire logic             memory_short,
	input  wire logic [15:0]      max_message_size,
	input  wire logic [23:0]      address_prefix,
	output fac_pkg::verdict_t     verdict,
	output logic                  pass
);
	import fac_pkg::*;

	logic [15:0] len;
	logic [15:0] len_m4;

	// truncate to the message size
	assign len    = (received_length < max_message_size) ? received_length : max_message_size;
	assign len_m4 = len - HDR_BYTES;

	// first failing check wins
	always_comb begin
		pass    = 1'b0;
		verdict = V_NOMEM;
		if (memory_short) begin
			verdict = V_NOMEM;
		end else if (len < HDR_BYTES) begin
			verdict = V_SHORT;
		end else if (header_length != {16'd0, len_m4}) begin
			verdict = V_MISMATCH;
		end else if (source_address[47:24] != address_prefix) begin
			verdict = V_FOREIGN;
		end else begin
			pass    = 1'b1;
			verdict = V_KNOWN;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fac_table.sv =====
`default_nettype none

// Suffix memory with a linear scan: one read issued and one compare done per cycle.
module fac_table #(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  fac_pkg::search_req_t      req,
	output fac_pkg::search_rsp_t      rsp
);
	import fac_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic {
		T_IDLE,
		T_SCAN
	} tstate_t;

	tstate_t             state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    cmp_idx_q;
	logic                cmp_vld_q;
	logic [23:0]         suffix_q;
	logic [23:0]         rd_data_q;
	logic [23:0]         mem [TABLE_ENTRIES];

	logic                rd_en;
	logic                wr_en;
	logic                hit;
	logic                more;
	logic                full;
	logic [CNT_W-1:0]    sel_idx;
	logic [CNT_W+7:0]    idx_ext;

	// shared compare and scan control
	assign hit     = cmp_vld_q && (rd_data_q == suffix_q);
	assign more    = rd_idx_q < count_q;
	assign full    = count_q == CNT_W'(TABLE_ENTRIES);
	assign rd_en   = (state_q == T_SCAN) && !hit && more;
	assign wr_en   = (state_q == T_SCAN) && !hit && !more && !full;
	assign sel_idx = hit ? cmp_idx_q : count_q;
	assign idx_ext = {8'd0, sel_idx};

	// suffix memory, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= suffix_q;
		end
	end

	// scan sequencer; done is a one-cycle pulse, cleared back in idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			cmp_vld_q   <= 1'b0;
			suffix_q    <= '0;
			rsp.done    <= 1'b0;
			rsp.verdict <= V_KNOWN;
			rsp.index   <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					rsp.done <= 1'b0;
					if (req.start) begin
						suffix_q  <= req.suffix;
						rd_idx_q  <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= T_SCAN;
					end
				end
				T_SCAN: begin
					if (hit) begin
						rsp.done    <= 1'b1;
						rsp.verdict <= V_KNOWN;
						rsp.index   <= idx_ext[7:0];
						cmp_vld_q   <= 1'b0;
						state_q     <= T_IDLE;
					end else if (more) begin
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= rd_idx_q;
						rd_idx_q  <= rd_idx_q + 1'b1;
					end else begin
						rsp.done  <= 1'b1;
						cmp_vld_q <= 1'b0;
						state_q   <= T_IDLE;
						if (full) begin
							rsp.verdict <= V_FULL;
							rsp.index   <= '0;
						end else begin
							rsp.verdict <= V_NEW;
							rsp.index   <= idx_ext[7:0];
							count_q     <= count_q + 1'b1;
						end
					end
				end
				default: begin
					rsp.done <= 1'b0;
					state_q  <= T_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/frame_admit_and_client_table.sv =====
`default_nettype none

// Frame admission and client table. Each input word describes one received
// frame; the block drops it for low memory, a length under four bytes after
// truncation to max_message_size, a header that is not length minus four, or
// an address prefix other than address_prefix, and otherwise looks the low 24
// address bits up in the client table, appending them when new and the table
// is not full. One result word comes out per input word. An item is latched,
// then checked, and an admitted frame is then searched among the N current
// clients (N at most TABLE_ENTRIES): one comparator walks the suffix memory
// one entry per cycle through its single read port. The result then loads the
// output register once that register is free. A new word is taken once the
// previous one sits in the output register. The table starts empty after
// reset; no clearing pass is needed.
module frame_admit_and_client_table #(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fac_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [15:0]                       received_length,
	input  wire logic [31:0]                       header_length,
	input  wire logic [47:0]                       source_address,
	input  wire logic                              memory_short,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             verdict,
	output logic [7:0]                             client_index
);
	import fac_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	state_t       state_q;
	logic [15:0]  max_msg_q;
	logic [23:0]  prefix_q;
	logic [15:0]  rlen_q;
	logic [31:0]  header_q;
	logic [47:0]  addr_q;
	logic         nomem_q;
	verdict_t     pend_verdict_q;
	logic [7:0]   pend_index_q;
	verdict_t     out_verdict_q;
	logic [7:0]   out_index_q;
	logic         out_valid_q;

	verdict_t     chk_verdict;
	logic         chk_pass;
	search_req_t  sreq;
	search_rsp_t  srsp;
	logic         out_free;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign verdict      = out_verdict_q;
	assign client_index = out_index_q;
	assign out_free     = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_q <= MAX_MSG_RST;
			prefix_q  <= PREFIX_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_MSG) begin
				max_msg_q <= cfg_data[15:0];
			end else if (cfg_index == REG_PREFIX) begin
				prefix_q <= cfg_data;
			end
		end
	end

	fac_check u_check (
		.received_length  (rlen_q),
		.header_length    (header_q),
		.source_address   (addr_q),
		.memory_short     (nomem_q),
		.max_message_size (max_msg_q),
		.address_prefix   (prefix_q),
		.verdict          (chk_verdict),
		.pass             (chk_pass)
	);

	assign sreq.start  = (state_q == ST_CHECK) && chk_pass;
	assign sreq.suffix = addr_q[23:0];

	fac_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	// input latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rlen_q   <= received_length;
			header_q <= header_length;
			addr_q   <= source_address;
			nomem_q  <= memory_short;
		end
	end

	// item sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pend_verdict_q <= V_KNOWN;
			pend_index_q   <= '0;
			out_verdict_q  <= V_KNOWN;
			out_index_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// in emit the output register is reloaded instead
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (chk_pass) begin
						state_q <= ST_SEARCH;
					end else begin
						pend_verdict_q <= chk_verdict;
						pend_index_q   <= '0;
						state_q        <= ST_EMIT;
					end
				end
				ST_SEARCH: begin
					if (srsp.done) begin
						pend_verdict_q <= srsp.verdict;
						pend_index_q   <= srsp.index;
						state_q        <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_verdict_q <= pend_verdict_q;
						out_index_q   <= pend_index_q;
						out_valid_q   <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fac_checker.sv =====
`default_nettype none

// Port-level checks on the admission block.
module fac_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] verdict,
	input wire logic [7:0] client_index
);
	import fac_pkg::*;

	// one word in flight: ready drops right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while previous word still in work");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(verdict)
			&& $stable(client_index)))
		else $error("result changed while stalled");

	// dropped frames and full table carry index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict != V_KNOWN && verdict != V_NEW) |-> (client_index == 8'd0))
		else $error("nonzero index on a dropped frame");

	// no undefined verdict code
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict <= V_FULL))
		else $error("undefined verdict code");

endmodule

bind frame_admit_and_client_table fac_checker u_fac_checker (.*);

`default_nettype wire
